>>> rtl/core/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg
// shared constants, types and codes of the round-robin poll scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package rrp_pkg;

  localparam int ENTRIES    = 256;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  // input item kinds, carried on in_tuser
  localparam logic [1:0] KIND_POLL = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_LINK = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LINK,
    ST_RESP
  } state_t;

  // outcome of one visited entry
  typedef struct packed {
    logic                  due;
    logic                  wr;
    logic [COUNT_BITS-1:0] cnt;
  } visit_t;

endpackage

`default_nettype wire

>>> rtl/core/rrp_ram.sv
// ----------------------------------------------------------------------------
// rrp_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/rrp_visit.sv
// ----------------------------------------------------------------------------
// rrp_visit
// decides one entry: skip and count up, serve and clear, or leave alone
// ----------------------------------------------------------------------------
`default_nettype none

module rrp_visit (
  input  wire logic [rrp_pkg::COUNT_BITS-1:0] period,
  input  wire logic [rrp_pkg::COUNT_BITS-1:0] counter,
  output rrp_pkg::visit_t                     res
);
  import rrp_pkg::*;

  always_comb begin
    res.due = 1'b0;
    res.wr  = 1'b0;
    res.cnt = '0;
    if (period != '0) begin
      res.wr = 1'b1;
      if (counter < period) begin
        res.cnt = counter + COUNT_BITS'(1);
      end else begin
        // due, also when the period was lowered below the counter
        res.due = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rate_divided_round_robin_poller.sv
// ----------------------------------------------------------------------------
// rate_divided_round_robin_poller
// picks the next table entry to poll, with a per-entry skip period
// ----------------------------------------------------------------------------
// poll: the scan reads one counter per cycle through one read port, from the scan
//   start over entries 1 to active count - 1, ending early when an entry is found due,
//   then waits for the output register; a link restore walks every active entry
// throughput: one item at a time; next item taken once the previous one is done
// reset: after rst_n the period and counter memories are swept to zero, one entry
//   per cycle, every entry in turn, and no item is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module rate_divided_round_robin_poller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: entry_count
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // entry_index[7:0], period[23:8], link_up[24]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // selected_entry[7:0], found[8]
);
  import rrp_pkg::*;

  // input field split
  logic [7:0]            in_entry_index;
  logic [15:0]           in_period;
  logic                  in_link_up;
  logic [1:0]            in_kind;
  logic                  in_xfer;

  assign in_entry_index = in_tdata[7:0];
  assign in_period      = in_tdata[23:8];
  assign in_link_up     = in_tdata[24];
  assign in_kind        = in_tuser;

  // control and pipeline registers
  state_t                state_r, state_nxt;
  logic [8:0]            entry_count_r;
  logic [IDX_W-1:0]      scan_start_r, scan_start_nxt;
  logic                  prev_link_r, prev_link_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;     // next entry to read
  logic [CNT_W-1:0]      left_r, left_nxt;         // reads still to issue
  logic                  v_r, v_nxt;               // read data valid this cycle
  logic [IDX_W-1:0]      ev_idx_r, ev_idx_nxt;     // entry whose data is back
  logic [IDX_W-1:0]      sel_r, sel_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_sel_r, out_sel_nxt;
  logic                  out_found_r, out_found_nxt;

  // memory ports
  logic                  per_we;
  logic [IDX_W-1:0]      per_waddr;
  logic [COUNT_BITS-1:0] per_wdata;
  logic [COUNT_BITS-1:0] per_rdata;
  logic                  ctr_we;
  logic [IDX_W-1:0]      ctr_waddr;
  logic [COUNT_BITS-1:0] ctr_wdata;
  logic [COUNT_BITS-1:0] ctr_rdata;
  logic [IDX_W-1:0]      rd_addr;

  visit_t                vis;

  // derived scan values
  logic [CNT_W-1:0]      act_count;
  logic [IDX_W-1:0]      start_idx;
  logic [IDX_W-1:0]      adv_idx;      // rd_idx_r + 1, wrapping to entry 1
  logic [IDX_W-1:0]      after_ev;     // next scan start after a served entry
  logic                  issue;

  assign act_count = (int'(entry_count_r) > ENTRIES) ? CNT_W'(ENTRIES)
                                                     : CNT_W'(entry_count_r);

  // out-of-range or zero start restarts at entry 1
  assign start_idx = ((scan_start_r == '0) || (CNT_W'(scan_start_r) >= act_count))
                     ? IDX_W'(1) : scan_start_r;

  assign adv_idx  = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == act_count)
                    ? IDX_W'(1) : rd_idx_r + IDX_W'(1);
  assign after_ev = ((CNT_W'(ev_idx_r) + CNT_W'(1)) < act_count)
                    ? ev_idx_r + IDX_W'(1) : IDX_W'(1);

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign rd_addr   = rd_idx_r;

  rrp_ram #(.WIDTH(COUNT_BITS), .DEPTH(ENTRIES)) u_period_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_waddr),
    .wdata (per_wdata),
    .raddr (rd_addr),
    .rdata (per_rdata)
  );

  rrp_ram #(.WIDTH(COUNT_BITS), .DEPTH(ENTRIES)) u_counter_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .raddr (rd_addr),
    .rdata (ctr_rdata)
  );

  rrp_visit u_visit (
    .period  (per_rdata),
    .counter (ctr_rdata),
    .res     (vis)
  );

  // next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    scan_start_nxt = scan_start_r;
    prev_link_nxt  = prev_link_r;
    rd_idx_nxt     = rd_idx_r;
    left_nxt       = left_r;
    v_nxt          = 1'b0;
    ev_idx_nxt     = rd_idx_r;
    sel_nxt        = sel_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sel_nxt    = out_sel_r;
    out_found_nxt  = out_found_r;
    per_we         = 1'b0;
    per_waddr      = rd_idx_r;
    per_wdata      = '0;
    ctr_we         = 1'b0;
    ctr_waddr      = ev_idx_r;
    ctr_wdata      = '0;
    issue          = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // zero both memories, one entry a cycle
        per_we     = 1'b1;
        ctr_we     = 1'b1;
        ctr_waddr  = rd_idx_r;
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
        left_nxt   = left_r - CNT_W'(1);
        if (left_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          case (in_kind)
            KIND_POLL: begin
              rd_idx_nxt = start_idx;
              left_nxt   = (act_count >= CNT_W'(2)) ? act_count - CNT_W'(1) : '0;
              state_nxt  = ST_SCAN;
            end
            KIND_LOAD: begin
              if (int'(in_entry_index) < ENTRIES) begin
                per_we    = 1'b1;
                per_waddr = IDX_W'(in_entry_index);
                per_wdata = COUNT_BITS'(in_period);
              end
            end
            KIND_LINK: begin
              prev_link_nxt = in_link_up;
              // only a down-to-up change restores counters
              if (!prev_link_r && in_link_up && (act_count != '0)) begin
                rd_idx_nxt = '0;
                left_nxt   = act_count;
                state_nxt  = ST_LINK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // one read issued per cycle, the entry read last cycle decided now
        issue = (left_r != '0) && !(v_r && vis.due);
        if (issue) begin
          v_nxt      = 1'b1;
          rd_idx_nxt = adv_idx;
          left_nxt   = left_r - CNT_W'(1);
        end
        if (v_r) begin
          ctr_we    = vis.wr;
          ctr_wdata = vis.cnt;
        end
        if (v_r && vis.due) begin
          sel_nxt        = ev_idx_r;
          found_nxt      = 1'b1;
          scan_start_nxt = after_ev;
          state_nxt      = ST_RESP;
        end else if (left_r == '0) begin
          sel_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_RESP;
        end
      end

      ST_LINK: begin
        // copy period into counter for entries below the active count
        issue = (left_r != '0);
        if (issue) begin
          v_nxt      = 1'b1;
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
          left_nxt   = left_r - CNT_W'(1);
        end
        if (v_r) begin
          ctr_we    = 1'b1;
          ctr_wdata = per_rdata;
          if (left_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_RESP: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sel_nxt   = 8'(sel_r);
          out_found_nxt = found_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      entry_count_r <= 9'd1;
      scan_start_r  <= IDX_W'(1);
      prev_link_r   <= 1'b1;
      rd_idx_r      <= '0;
      left_r        <= CNT_W'(ENTRIES);
      v_r           <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      scan_start_r  <= scan_start_nxt;
      prev_link_r   <= prev_link_nxt;
      rd_idx_r      <= rd_idx_nxt;
      left_r        <= left_nxt;
      v_r           <= v_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ev_idx_r    <= ev_idx_nxt;
    sel_r       <= sel_nxt;
    found_r     <= found_nxt;
    out_sel_r   <= out_sel_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_found_r, out_sel_r};

  // checks

  // scan start never rests on entry 0
  a_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    scan_start_r != '0)
    else $error("scan start became zero");

  // a new result only comes out of the response state
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESP)
    else $error("result raised outside response state");

  // a served entry is always a real, nonzero entry below the count
  a_found_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && found_r) |-> (sel_r != '0 && CNT_W'(sel_r) < act_count))
    else $error("served entry out of range");

  // scan reads never outrun the active count
  a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> (left_r == '0 || left_r < act_count))
    else $error("scan read count exceeds active count");

endmodule

`default_nettype wire
